// File: rtl/mts_pkg.sv
`default_nettype none
package mts_pkg;

	localparam int DEFAULT_STACK_DEPTH = 32;
	localparam int DEFAULT_WORD_BITS   = 32;
	localparam int FIELD_W             = 32;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic                      action;
		logic signed [FIELD_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] popped_value;
		logic signed [FIELD_W-1:0] current_min;
		logic                      min_valid;
		logic                      now_empty;
		status_t                   status;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic commit;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic good_pop;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/min_tracking_stack.sv
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    in_data  (in_item_t: action, push_value)
// out       out  out_valid / out_stall  out_data (out_item_t: popped_value, current_min,
//                                                 min_valid, now_empty, status)
//
// one item at a time: after its transfer a push or failed pop passes through EXEC and
// EMIT, loading the result register as it leaves EMIT, and the next transfer waits for
// IDLE; a good pop adds POPRD between them for the registered read of both store ports
// in_stall is high from the transfer until the result is loaded
// a result waiting under out_stall holds the block in its final step
// arst_n clears both counts and the sequencer; stores need no clearing
`default_nettype none
module min_tracking_stack
	import mts_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	parameter int WORD_BITS   = DEFAULT_WORD_BITS
) (
	input  wire  logic      clk,
	input  wire  logic      arst_n,
	input  wire  logic      in_valid,
	output logic            in_stall,
	input  wire  in_item_t  in_data,
	output logic            out_valid,
	input  wire  logic      out_stall,
	output out_item_t       out_data
);

	cmd_t cmd;
	sts_t sts;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mts_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in flight");

	a_empty_vs_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.now_empty != out_data.min_valid))
		else $error("empty flag and min valid disagree");

	a_overflow_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_OVERFLOW) |-> !out_data.now_empty)
		else $error("overflow reported on empty stack");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_UNDERFLOW) |-> out_data.now_empty)
		else $error("underflow reported on non-empty stack");

endmodule
`default_nettype wire

// File: rtl/mts_ctrl.sv
`default_nettype none
module mts_ctrl
	import mts_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  wire  logic out_stall,
	input  wire  sts_t sts,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_POPRD = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = sts.good_pop ? S_POPRD : S_EMIT;
			end
			S_POPRD: begin
				cmd.commit = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/mts_datapath.sv
`default_nettype none
module mts_datapath
	import mts_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	parameter int WORD_BITS   = DEFAULT_WORD_BITS
) (
	input  wire  logic     clk,
	input  wire  logic     arst_n,
	input  wire  in_item_t in_data,
	input  wire  cmd_t     cmd,
	output sts_t           sts,
	output out_item_t      out_data
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [WORD_BITS-1:0] SIGN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic [WORD_BITS-1:0] value_mem [STACK_DEPTH];
	logic [WORD_BITS-1:0] min_mem   [STACK_DEPTH];

	logic                 action_q;
	logic [WORD_BITS-1:0] word_q;
	logic [CNT_W-1:0]     vcnt_q;
	logic [CNT_W-1:0]     mcnt_q;
	logic [WORD_BITS-1:0] min_top_q;
	logic [WORD_BITS-1:0] popped_q;
	status_t              status_q;
	logic [WORD_BITS-1:0] vrd_q;
	logic [WORD_BITS-1:0] mrd_q;
	out_item_t            out_q;

	logic [CNT_W-1:0]     vcnt_m1;
	logic [CNT_W-1:0]     mcnt_m2;
	logic                 full;
	logic                 empty;
	logic                 min_push;
	logic                 min_pop;
	logic [WORD_BITS-1:0] cur_min;

	assign vcnt_m1  = vcnt_q - CNT_W'(1);
	assign mcnt_m2  = mcnt_q - CNT_W'(2);
	assign full     = (vcnt_q == CNT_W'(STACK_DEPTH));
	assign empty    = (vcnt_q == '0);
	assign min_push = (mcnt_q == '0) || !($signed(min_top_q) < $signed(word_q));
	assign min_pop  = (mcnt_q != '0) && (min_top_q == vrd_q);
	assign cur_min  = (mcnt_q != '0) ? min_top_q : SIGN_WORD;
	assign sts.good_pop = (action_q == ACT_POP) && !empty;
	assign out_data = out_q;

	// store ports
	always_ff @(posedge clk) begin
		if (cmd.exec && action_q == ACT_PUSH && !full) begin
			value_mem[vcnt_q[ADDR_W-1:0]] <= word_q;
			if (min_push) begin
				min_mem[mcnt_q[ADDR_W-1:0]] <= word_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			vrd_q <= value_mem[vcnt_m1[ADDR_W-1:0]];
			mrd_q <= min_mem[mcnt_m2[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			mcnt_q <= '0;
		end else if (cmd.exec) begin
			if (action_q == ACT_PUSH && !full) begin
				vcnt_q <= vcnt_q + CNT_W'(1);
				if (min_push) begin
					mcnt_q <= mcnt_q + CNT_W'(1);
				end
			end
		end else if (cmd.commit) begin
			vcnt_q <= vcnt_m1;
			if (min_pop) begin
				mcnt_q <= mcnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= in_data.action;
			word_q <= WORD_BITS'($unsigned(in_data.push_value));
		end
		if (cmd.exec) begin
			popped_q <= SIGN_WORD;
			if (action_q == ACT_PUSH && full) begin
				status_q <= ST_OVERFLOW;
			end else if (action_q == ACT_POP && empty) begin
				status_q <= ST_UNDERFLOW;
			end else begin
				status_q <= ST_OK;
			end
			if (action_q == ACT_PUSH && !full && min_push) begin
				min_top_q <= word_q;
			end
		end
		if (cmd.commit) begin
			popped_q <= vrd_q;
			if (min_pop) begin
				min_top_q <= mrd_q;
			end
		end
		if (cmd.emit) begin
			out_q.popped_value <= $signed(FIELD_W'(popped_q));
			out_q.current_min <= $signed(FIELD_W'(cur_min));
			out_q.min_valid <= (mcnt_q != '0);
			out_q.now_empty <= empty;
			out_q.status <= status_q;
		end
	end

endmodule
`default_nettype wire
